// ===== design/fpd_pkg.sv =====
// Shared types, constants and the stencil coefficient table for the five-point
// derivative stream. No dependencies; every other design file refers to it by scope.

package fpd_pkg;

	// Sample format and window geometry.
	localparam int SAMPLE_BITS = 32;
	localparam int WIN_LEN     = 5;
	localparam int TAP_IDX_W   = $clog2(WIN_LEN);
	localparam int CNT_W       = $clog2(WIN_LEN + 1);

	// Coefficients span -48 to 48; the absolute coefficients of one stencil sum to 128 at most.
	localparam int COEF_W = 7;
	localparam int TAP_W  = SAMPLE_BITS + COEF_W;
	localparam int SUM_W  = SAMPLE_BITS + 8;

	// The magnitude is split at 32 bits for the two reciprocal products.
	localparam int SPLIT_W = 32;
	localparam int MAG_W   = (SUM_W > SPLIT_W + 1) ? SUM_W : SPLIT_W + 1;
	localparam int HI_W    = MAG_W - SPLIT_W;

	// Configuration register and product widths.
	localparam int CFG_W  = 32;
	localparam int LO_P_W = SPLIT_W + CFG_W;
	localparam int HI_P_W = HI_W + CFG_W;
	localparam int Q_W    = 64;

	// Q16.16 scaling: drop 16 fraction bits with rounding half away from zero.
	localparam int FRAC_W       = 16;
	localparam int HI_SAT_SHIFT = 40;
	localparam logic [Q_W-1:0] ROUND_HALF = Q_W'(1) << (FRAC_W - 1);
	localparam logic [Q_W-1:0] HI_SAT_LIM = Q_W'(1) << HI_SAT_SHIFT;
	localparam logic [Q_W-1:0] MAG_LIM    = Q_W'(1) << (SAMPLE_BITS - 1);

	// Reset value of the reciprocal register: 1.0 in Q16.16.
	localparam logic [CFG_W-1:0] INV_RESET = CFG_W'(1) << FRAC_W;

	// Job queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Stencil kinds in the order they are emitted for one sequence.
	typedef enum logic [2:0] {
		K_FWD_EDGE,
		K_FWD_NEXT,
		K_CENTRAL,
		K_BWD_NEXT,
		K_BWD_EDGE,
		K_ZERO
	} kind_t;

	// One job: a window snapshot plus a run of consecutive stencil kinds.
	typedef struct packed {
		logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] win;
		kind_t                               kind_lo;
		logic [CNT_W-1:0]                    count;
		logic                                zero;
		logic                                ends;
	} job_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	// Flags that travel with each result through the back pipeline.
	typedef struct packed {
		logic last;
		logic done;
	} tag_t;

	typedef logic signed [COEF_W-1:0] coef_row_t [WIN_LEN];

	// Tap weights, oldest sample first.
	localparam coef_row_t FWD_EDGE_C = '{-7'sd25, 7'sd48, -7'sd36, 7'sd16, -7'sd3};
	localparam coef_row_t FWD_NEXT_C = '{-7'sd3, -7'sd10, 7'sd18, -7'sd6, 7'sd1};
	localparam coef_row_t CENTRAL_C  = '{7'sd1, -7'sd8, 7'sd0, 7'sd8, -7'sd1};
	localparam coef_row_t BWD_NEXT_C = '{-7'sd1, 7'sd6, -7'sd18, 7'sd10, 7'sd3};
	localparam coef_row_t BWD_EDGE_C = '{7'sd3, -7'sd16, 7'sd36, -7'sd48, 7'sd25};

	// Weight of one tap for one stencil; the zero kind weighs every tap by zero.
	function automatic logic signed [COEF_W-1:0] coef(kind_t k, logic [TAP_IDX_W-1:0] tap);
		logic signed [COEF_W-1:0] c;
		c = '0;
		unique case (k)
			K_FWD_EDGE: c = FWD_EDGE_C[tap];
			K_FWD_NEXT: c = FWD_NEXT_C[tap];
			K_CENTRAL:  c = CENTRAL_C[tap];
			K_BWD_NEXT: c = BWD_NEXT_C[tap];
			K_BWD_EDGE: c = BWD_EDGE_C[tap];
			default:    c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== design/fpd_front.sv =====
// Front part: accepts sample beats, keeps the sliding window and the sample count,
// and turns each beat into at most one job for the queue. Depends on fpd_pkg.

module fpd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  fpd_pkg::sample_t   sample_value,
	input  logic               end_of_sequence,
	input  logic               in_valid,
	output logic               in_ready,
	input  fpd_pkg::q_stat_t   q_stat,
	output logic               push,
	output fpd_pkg::job_t      push_job
);

	localparam logic [fpd_pkg::CNT_W-1:0] FULL_CNT = fpd_pkg::CNT_W'(fpd_pkg::WIN_LEN);
	localparam logic [fpd_pkg::CNT_W-1:0] ONE_CNT  = fpd_pkg::CNT_W'(1);

	logic [fpd_pkg::SAMPLE_BITS-1:0] win_q    [fpd_pkg::WIN_LEN];
	logic [fpd_pkg::SAMPLE_BITS-1:0] win_next [fpd_pkg::WIN_LEN];
	logic [fpd_pkg::CNT_W-1:0]       seen_q;
	logic [fpd_pkg::CNT_W-1:0]       seen_next;
	logic                            accept;
	logic                            win_full;
	logic                            first_full;
	fpd_pkg::kind_t                  kind_hi;

	// A beat is taken whenever the queue has room for its job.
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// Window shifted by the incoming sample, and the saturating count.
	always_comb begin
		for (int i = 0; i < fpd_pkg::WIN_LEN - 1; i++) begin
			win_next[i] = win_q[i+1];
		end
		win_next[fpd_pkg::WIN_LEN-1] = sample_value;
		seen_next  = (seen_q < FULL_CNT) ? seen_q + ONE_CNT : seen_q;
		win_full   = (seen_next == FULL_CNT);
		first_full = (seen_q == FULL_CNT - ONE_CNT);
	end

	// Classify the beat: a run of stencils over the full window, or zeros for a short sequence.
	always_comb begin
		for (int i = 0; i < fpd_pkg::WIN_LEN; i++) begin
			push_job.win[i] = win_next[i];
		end
		push_job.ends = end_of_sequence;
		kind_hi       = end_of_sequence ? fpd_pkg::K_BWD_EDGE : fpd_pkg::K_CENTRAL;
		if (win_full) begin
			push_job.zero    = 1'b0;
			push_job.kind_lo = first_full ? fpd_pkg::K_FWD_EDGE : fpd_pkg::K_CENTRAL;
			push_job.count   = fpd_pkg::CNT_W'(kind_hi) - fpd_pkg::CNT_W'(push_job.kind_lo)
				+ ONE_CNT;
		end else begin
			push_job.zero    = 1'b1;
			push_job.kind_lo = fpd_pkg::K_ZERO;
			push_job.count   = seen_next;
		end
		push = accept && (win_full || end_of_sequence);
	end

	// Window storage, cleared at reset so that the zero results of a short sequence
	// never see undefined taps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '{default: '0};
		end else if (accept) begin
			win_q <= win_next;
		end
	end

	// Sample count, cleared at the end of each sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= end_of_sequence ? '0 : seen_next;
		end
	end

endmodule

// ===== design/fpd_queue.sv =====
// Short job queue that decouples the front part from the back part.
// Depends on fpd_pkg for the job type and depth.

module fpd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fpd_pkg::job_t    push_job,
	input  logic             pop,
	output fpd_pkg::job_t    head,
	output fpd_pkg::q_stat_t q_stat
);

	localparam logic [fpd_pkg::QCNT_W-1:0] DEPTH_CNT = fpd_pkg::QCNT_W'(fpd_pkg::QDEPTH);
	localparam logic [fpd_pkg::QCNT_W-1:0] ONE_CNT   = fpd_pkg::QCNT_W'(1);
	localparam logic [fpd_pkg::QPTR_W-1:0] ONE_PTR   = fpd_pkg::QPTR_W'(1);

	fpd_pkg::job_t                 job_q [fpd_pkg::QDEPTH];
	logic [fpd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [fpd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [fpd_pkg::QCNT_W-1:0]    count_q;

	assign head             = job_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.full      = (count_q == DEPTH_CNT);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ONE_PTR;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ONE_PTR;
			end
			if (push && !pop) begin
				count_q <= count_q + ONE_CNT;
			end else if (pop && !push) begin
				count_q <= count_q - ONE_CNT;
			end
		end
	end

	// The front never writes a full queue, and the back never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("job queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("job queue count beyond depth");

endmodule

// ===== design/fpd_back.sv =====
// Back part: steps through the stencils of the head job and carries each through
// tap products, sum, magnitude, reciprocal product, rounding and saturation into
// the output register, one result a cycle unless it stalls. Depends on fpd_pkg.

module fpd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpd_pkg::q_stat_t             q_stat,
	input  fpd_pkg::job_t                head,
	output logic                         pop,
	input  logic [fpd_pkg::CFG_W-1:0]    inv_step,
	output fpd_pkg::sample_t             derivative_value,
	output logic                         last_of_run,
	output logic                         sequence_done,
	output logic                         out_valid,
	input  logic                         out_ready
);

	localparam logic [fpd_pkg::CNT_W-1:0] ONE_CNT = fpd_pkg::CNT_W'(1);

	logic                              adv;
	logic                              issue;
	logic                              step_last;
	logic [fpd_pkg::CNT_W-1:0]         step_q;
	fpd_pkg::kind_t                    kind;
	logic signed [fpd_pkg::COEF_W-1:0] coef_c [fpd_pkg::WIN_LEN];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	fpd_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	logic signed [fpd_pkg::TAP_W-1:0]  taps_s1 [fpd_pkg::WIN_LEN];
	logic signed [fpd_pkg::SUM_W-1:0]  tap_sum;
	logic signed [fpd_pkg::SUM_W-1:0]  sum_s2;
	logic signed [fpd_pkg::SUM_W-1:0]  sum_abs;
	logic                              neg_s3, neg_s4, neg_s5;
	logic [fpd_pkg::MAG_W-1:0]         mag_s3;
	logic [fpd_pkg::LO_P_W-1:0]        lo_s4;
	logic [fpd_pkg::HI_P_W-1:0]        hi_s4;
	logic [fpd_pkg::Q_W-1:0]           hi_wide;
	logic [fpd_pkg::Q_W-1:0]           q_s5;
	logic                              sat_s5;
	logic [fpd_pkg::Q_W-1:0]           q_sat;
	logic [fpd_pkg::Q_W-1:0]           q_clip;
	logic [fpd_pkg::SAMPLE_BITS-1:0]   val_s6;

	// The whole pipeline moves unless a finished result waits on the output.
	assign adv       = !v_s6 || out_ready;
	assign issue     = q_stat.not_empty && adv;
	assign step_last = (step_q == head.count - ONE_CNT);
	assign pop       = issue && step_last;

	// Stencil kind for the current step of the head job.
	always_comb begin
		if (head.zero) begin
			kind = fpd_pkg::K_ZERO;
		end else begin
			kind = fpd_pkg::kind_t'(3'(head.kind_lo) + 3'(step_q));
		end
		for (int i = 0; i < fpd_pkg::WIN_LEN; i++) begin
			coef_c[i] = fpd_pkg::coef(kind, fpd_pkg::TAP_IDX_W'(i));
		end
	end

	// Step counter within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (issue) begin
			step_q <= step_last ? '0 : step_q + ONE_CNT;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Sum of the weighted taps and its magnitude.
	always_comb begin
		tap_sum = '0;
		for (int i = 0; i < fpd_pkg::WIN_LEN; i++) begin
			tap_sum = tap_sum + fpd_pkg::SUM_W'(taps_s1[i]);
		end
		sum_abs = sum_s2[fpd_pkg::SUM_W-1] ? -sum_s2 : sum_s2;
	end

	// Rounded quotient before saturation, and clipping to the signed range.
	always_comb begin
		hi_wide = fpd_pkg::Q_W'(hi_s4);
		q_sat   = sat_s5 ? fpd_pkg::MAG_LIM : q_s5;
		if (neg_s5) begin
			q_clip = (q_sat > fpd_pkg::MAG_LIM) ? fpd_pkg::MAG_LIM : q_sat;
		end else begin
			q_clip = (q_sat > fpd_pkg::MAG_LIM - fpd_pkg::Q_W'(1))
				? fpd_pkg::MAG_LIM - fpd_pkg::Q_W'(1) : q_sat;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: one product per tap.
			tag_s1.last <= step_last;
			tag_s1.done <= step_last && head.ends;
			for (int i = 0; i < fpd_pkg::WIN_LEN; i++) begin
				taps_s1[i] <= fpd_pkg::TAP_W'(coef_c[i])
					* fpd_pkg::TAP_W'($signed(head.win[i]));
			end
			// Stage 2: weighted sum.
			tag_s2 <= tag_s1;
			sum_s2 <= tap_sum;
			// Stage 3: sign and magnitude.
			tag_s3 <= tag_s2;
			neg_s3 <= sum_s2[fpd_pkg::SUM_W-1];
			mag_s3 <= fpd_pkg::MAG_W'($unsigned(sum_abs));
			// Stage 4: reciprocal products of the low and high magnitude parts.
			tag_s4 <= tag_s3;
			neg_s4 <= neg_s3;
			lo_s4  <= fpd_pkg::LO_P_W'(mag_s3[fpd_pkg::SPLIT_W-1:0])
				* fpd_pkg::LO_P_W'(inv_step);
			hi_s4  <= fpd_pkg::HI_P_W'(mag_s3[fpd_pkg::MAG_W-1:fpd_pkg::SPLIT_W])
				* fpd_pkg::HI_P_W'(inv_step);
			// Stage 5: recombine with rounding, flag overflow of the high part.
			tag_s5 <= tag_s4;
			neg_s5 <= neg_s4;
			sat_s5 <= (hi_wide >= fpd_pkg::HI_SAT_LIM);
			q_s5   <= (hi_wide << fpd_pkg::FRAC_W)
				+ ((fpd_pkg::Q_W'(lo_s4) + fpd_pkg::ROUND_HALF) >> fpd_pkg::FRAC_W);
			// Stage 6: signed, saturated result in the output register.
			tag_s6 <= tag_s5;
			val_s6 <= fpd_pkg::SAMPLE_BITS'(neg_s5 ? (~q_clip + fpd_pkg::Q_W'(1)) : q_clip);
		end
	end

	assign out_valid        = v_s6;
	assign derivative_value = val_s6;
	assign last_of_run      = tag_s6.last;
	assign sequence_done    = tag_s6.done;

	// The step counter stays inside the head job's run.
	a_step_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.not_empty |-> (step_q < head.count))
		else $error("step counter beyond the run of the head job");

	// The final grid point always closes the run of its beat.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sequence_done) |-> last_of_run)
		else $error("sequence end without end of run");

	// The counter is back at zero after a job leaves the queue.
	a_step_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == '0))
		else $error("step counter not cleared after pop");

endmodule

// ===== design/five_point_derivative_stream.sv =====
// Five-point derivative stream: Q16.16 samples in, fourth-order first derivative out.
// Usage:
// Samples arrive as beats on the in channel (sample_value, end_of_sequence) with
// in_valid and in_ready. Results leave as beats on the out channel
// (derivative_value, last_of_run, sequence_done) with out_valid and out_ready.
// The reciprocal of twelve times the step is written on the cfg channel
// (cfg_data, cfg_valid, cfg_ready); cfg_ready is always high. The value is applied
// at the product stage, so write it only while no result is in flight.
// The job of an accepted beat passes through the job queue and then the tap product,
// sum, magnitude, reciprocal product and rounding registers into the output register.
// Throughput: the back part issues one result per cycle while the out channel is not
// stalled, so one sample per cycle is sustained while each beat causes one result.
// The fifth sample of a sequence causes three results and a final sample causes
// up to five; the four-entry job queue absorbs those bursts.
// Reset clears the sample count, queue and pipeline and sets the reciprocal to 1.0.
// A stalled receiver holds the output register; the pipeline stops behind it,
// the queue fills, and in_ready falls when the queue is full.
// Depends on fpd_pkg, fpd_front, fpd_queue and fpd_back.

module five_point_derivative_stream (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fpd_pkg::sample_t            sample_value,
	input  logic                        end_of_sequence,
	input  logic                        in_valid,
	output logic                        in_ready,
	output fpd_pkg::sample_t            derivative_value,
	output logic                        last_of_run,
	output logic                        sequence_done,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  logic [fpd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready
);

	logic [fpd_pkg::CFG_W-1:0] inv_step_q;
	fpd_pkg::q_stat_t          q_stat;
	fpd_pkg::job_t             push_job;
	fpd_pkg::job_t             head;
	logic                      push;
	logic                      pop;

	// Reciprocal register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_step_q <= fpd_pkg::INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inv_step_q <= cfg_data;
		end
	end

	// Front part: window and classification.
	fpd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_value    (sample_value),
		.end_of_sequence (end_of_sequence),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.q_stat          (q_stat),
		.push            (push),
		.push_job        (push_job)
	);

	// Job queue.
	fpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Back part: stencil evaluation and scaling.
	fpd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_stat           (q_stat),
		.head             (head),
		.pop              (pop),
		.inv_step         (inv_step_q),
		.derivative_value (derivative_value),
		.last_of_run      (last_of_run),
		.sequence_done    (sequence_done),
		.out_valid        (out_valid),
		.out_ready        (out_ready)
	);

endmodule
